[rtl/core/klr_pkg.sv]
// klr_pkg: shared types and constants for the key long-press / auto-repeat core
// no dependencies; used by the interfaces and all core modules
`timescale 1ns / 1ps

package klr_pkg;

    localparam int unsigned NUM_KEYS    = 16;
    localparam int unsigned MASK_W      = 16;
    localparam int unsigned TIMER_W     = 16;
    localparam int unsigned CFG_W       = 15;
    localparam int unsigned CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD   = 1'b1;

    localparam logic [CFG_W-1:0] LONG_PRESS_TIME_RST = 15'd500;
    localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST   = 15'd200;

    typedef logic [MASK_W-1:0]  t_mask;
    typedef logic [TIMER_W-1:0] t_timer;

    // effective timing thresholds shared by every key
    typedef struct packed {
        logic [CFG_W-1:0] hold_limit;
        logic [CFG_W-1:0] period;
        t_timer           repeat_thresh;
    } t_key_cfg;

    // per-key update result
    typedef struct packed {
        t_timer hold_timer;
        logic   repeat_mode;
        logic   noted;
        logic   lp_event;
    } t_key_res;

endpackage

[rtl/core/klr_scan_if.sv]
// klr_scan_if: scan transaction channel (pressed mask and elapsed time)
// depends on klr_pkg
`timescale 1ns / 1ps

interface klr_scan_if;
    logic            valid;
    logic            ready;
    klr_pkg::t_mask  pressed_keys;
    klr_pkg::t_timer elapsed_ms;

    modport source (output valid, output pressed_keys, output elapsed_ms, input ready);
    modport sink   (input valid, input pressed_keys, input elapsed_ms, output ready);
endinterface

[rtl/core/klr_event_if.sv]
// klr_event_if: event transaction channel (click, long-press and repeat masks)
// depends on klr_pkg
`timescale 1ns / 1ps

interface klr_event_if;
    logic           valid;
    logic           ready;
    klr_pkg::t_mask click_keys;
    klr_pkg::t_mask long_press_keys;
    klr_pkg::t_mask repeat_keys;

    modport source (output valid, output click_keys, output long_press_keys,
                    output repeat_keys, input ready);
    modport sink   (input valid, input click_keys, input long_press_keys,
                    input repeat_keys, output ready);
endinterface

[rtl/core/klr_key_unit.sv]
// klr_key_unit: next-state logic of one key's hold timer and repeat flag
// depends on klr_pkg
`timescale 1ns / 1ps

module klr_key_unit (
    input  logic              i_pressed,
    input  klr_pkg::t_timer   i_elapsed_ms,
    input  klr_pkg::t_timer   i_hold_timer,
    input  logic              i_repeat_mode,
    input  klr_pkg::t_key_cfg i_cfg,
    output klr_pkg::t_key_res o_res
);

    logic [klr_pkg::TIMER_W:0] sum;
    klr_pkg::t_timer           t_sat;
    klr_pkg::t_timer           t_hold;
    logic                      f_hold;
    logic                      rel_click;
    logic                      long_hit;
    logic                      rep_hit;
    klr_pkg::t_timer           lp_ext;

    always_comb begin
        lp_ext = {1'b0, i_cfg.hold_limit};
        sum    = {1'b0, i_hold_timer} + {1'b0, i_elapsed_ms};
        t_sat  = sum[klr_pkg::TIMER_W] ? {klr_pkg::TIMER_W{1'b1}} : sum[klr_pkg::TIMER_W-1:0];

        if (i_pressed) begin
            t_hold    = t_sat;
            f_hold    = i_repeat_mode;
            rel_click = 1'b0;
        end else begin
            t_hold    = '0;
            f_hold    = 1'b0;
            rel_click = (i_hold_timer != '0) && (i_hold_timer < lp_ext);
        end

        long_hit = (t_hold >= lp_ext) && !f_hold;
        rep_hit  = (t_hold >= i_cfg.repeat_thresh);

        o_res.hold_timer  = rep_hit ? (t_hold - {1'b0, i_cfg.period}) : t_hold;
        o_res.repeat_mode = f_hold | long_hit;
        o_res.noted       = rel_click | rep_hit;
        o_res.lp_event    = long_hit;
    end

endmodule

[rtl/core/keypad_click_longpress_repeat_core.sv]
// keypad_click_longpress_repeat_core: top level of the key long-press / auto-repeat core
// depends on klr_pkg, klr_scan_if, klr_event_if and klr_key_unit
`timescale 1ns / 1ps

// usage
//  - i_scan carries one scan per transaction: pressed_keys mask and elapsed_ms
//  - o_event returns exactly one transaction per scan: click, long-press and
//    repeat masks, in scan order
//  - configuration: i_cfg_we with i_cfg_idx 0 writes long_press_time, 1 writes
//    repeat_period (low 15 bits of i_cfg_data); write only while idle
//  - a scan accepted into the input register gives its events valid once it
//    advances into the result register (one input register, one result register)
//  - throughput: one scan per cycle while o_event is not stalled; all keys update in
//    parallel in the single combinational pass between the input and result registers
//  - a stalled o_event holds its transaction; the input register still takes
//    one more scan, then i_scan.ready drops until the result is taken
//  - reset clears all hold timers and repeat flags, empties both registers and
//    loads 500 ms long-press time and 200 ms repeat period

module keypad_click_longpress_repeat_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [klr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [klr_pkg::CFG_W-1:0]    i_cfg_data,
    klr_scan_if.sink                     i_scan,
    klr_event_if.source                  o_event
);

    logic [klr_pkg::CFG_W-1:0] r_lp_time;
    logic [klr_pkg::CFG_W-1:0] r_repeat_period;

    logic            r_in_valid;
    klr_pkg::t_mask  r_in_keys;
    klr_pkg::t_timer r_in_elapsed;

    klr_pkg::t_timer r_hold_timer [klr_pkg::NUM_KEYS];
    klr_pkg::t_mask  r_repeat_mode;

    logic            r_out_valid;
    klr_pkg::t_mask  r_click;
    klr_pkg::t_mask  r_long_hit;
    klr_pkg::t_mask  r_repeat;

    logic              advance;
    klr_pkg::t_key_cfg key_cfg;
    klr_pkg::t_key_res key_res [klr_pkg::NUM_KEYS];
    klr_pkg::t_mask    n_repeat_mode;
    klr_pkg::t_mask    n_noted;
    klr_pkg::t_mask    n_long_hit;

    assign advance      = r_in_valid && (!r_out_valid || o_event.ready);
    assign i_scan.ready = !r_in_valid || advance;

    assign o_event.valid           = r_out_valid;
    assign o_event.click_keys      = r_click;
    assign o_event.long_press_keys = r_long_hit;
    assign o_event.repeat_keys     = r_repeat;

    // zero register value acts as one
    always_comb begin
        key_cfg.hold_limit = (r_lp_time == '0) ? klr_pkg::CFG_W'(1) : r_lp_time;
        key_cfg.period     = (r_repeat_period == '0) ? klr_pkg::CFG_W'(1) : r_repeat_period;
        key_cfg.repeat_thresh = {1'b0, key_cfg.hold_limit} + {1'b0, key_cfg.period};
    end

    for (genvar g = 0; g < klr_pkg::NUM_KEYS; g++) begin : g_key
        klr_key_unit u_key (
            .i_pressed     (r_in_keys[g]),
            .i_elapsed_ms  (r_in_elapsed),
            .i_hold_timer  (r_hold_timer[g]),
            .i_repeat_mode (r_repeat_mode[g]),
            .i_cfg         (key_cfg),
            .o_res         (key_res[g])
        );
    end

    always_comb begin
        n_repeat_mode = '0;
        n_noted       = '0;
        n_long_hit    = '0;
        for (int k = 0; k < klr_pkg::NUM_KEYS; k++) begin
            n_repeat_mode[k] = key_res[k].repeat_mode;
            n_noted[k]       = key_res[k].noted;
            n_long_hit[k]    = key_res[k].lp_event;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp_time       <= klr_pkg::LONG_PRESS_TIME_RST;
            r_repeat_period <= klr_pkg::REPEAT_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                klr_pkg::REG_LONG_PRESS_TIME: r_lp_time       <= i_cfg_data;
                klr_pkg::REG_REPEAT_PERIOD:   r_repeat_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_scan.ready) begin
            r_in_valid <= i_scan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.valid && i_scan.ready) begin
            r_in_keys    <= i_scan.pressed_keys;
            r_in_elapsed <= i_scan.elapsed_ms;
        end
    end

    // key state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_mode <= '0;
            for (int k = 0; k < klr_pkg::NUM_KEYS; k++) begin
                r_hold_timer[k] <= '0;
            end
        end else if (advance) begin
            r_repeat_mode <= n_repeat_mode;
            for (int k = 0; k < klr_pkg::NUM_KEYS; k++) begin
                r_hold_timer[k] <= key_res[k].hold_timer;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_click    <= n_noted & ~n_repeat_mode;
            r_long_hit <= n_long_hit;
            r_repeat   <= n_noted & n_repeat_mode;
        end
    end

    a_click_repeat_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_click & r_repeat) == '0))
        else $error("click and repeat reported for the same key");

    a_long_press_sets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_long_hit & ~r_repeat_mode) == '0))
        else $error("long press without repeat mode");

    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_scan.ready)
        else $error("input stalled with empty result register");

endmodule
